>>> rtl/turtle_grid_plotter_assert.svh
// Assertion macros, clocked on aclk, held off during reset.
`ifndef TURTLE_GRID_PLOTTER_ASSERT_SVH
`define TURTLE_GRID_PLOTTER_ASSERT_SVH

`define TGP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tgp_pkg.sv
`default_nettype none

package tgp_pkg;

    localparam int GRID_SIZE_DEF = 32;

    localparam int ACTION_W = 4;
    localparam int DIST_W   = 16;
    localparam int RC_W     = 5;
    localparam int HEAD_W   = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE      = 4'd0,
        ACT_PEN_UP    = 4'd1,
        ACT_PEN_DOWN  = 4'd2,
        ACT_RIGHT     = 4'd3,
        ACT_LEFT      = 4'd4,
        ACT_FORWARD   = 4'd5,
        ACT_READ      = 4'd6,
        ACT_MARK_ON   = 4'd7,
        ACT_MARK_OFF  = 4'd8,
        ACT_RESET     = 4'd9
    } action_t;

    localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd3;

    typedef struct packed {
        logic load;
        logic decode;
        logic plan;
        logic sweep;
        logic finish;
    } tgp_cmd_t;

    typedef struct packed {
        logic is_move;
        logic sweep_go;
        logic sweep_last;
        logic out_free;
    } tgp_sts_t;

endpackage

`default_nettype wire

>>> rtl/tgp_ram.sv
`default_nettype none

module tgp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/tgp_ctrl.sv
`default_nettype none

module tgp_ctrl
    import tgp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire tgp_sts_t sts,
    output tgp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAN,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_DECODE;
                end
                ST_DECODE: begin
                    state_reg <= sts.is_move ? ST_PLAN : ST_FINISH;
                end
                ST_PLAN: begin
                    state_reg <= sts.sweep_go ? ST_SWEEP : ST_FINISH;
                end
                ST_SWEEP: begin
                    if (sts.sweep_last) state_reg <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (sts.out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.load   = s_ready && s_valid;
    assign cmd.decode = (state_reg == ST_DECODE);
    assign cmd.plan   = (state_reg == ST_PLAN);
    assign cmd.sweep  = (state_reg == ST_SWEEP);
    assign cmd.finish = (state_reg == ST_FINISH);

endmodule

`default_nettype wire

>>> rtl/tgp_dp.sv
`default_nettype none

module tgp_dp
    import tgp_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire tgp_cmd_t                 cmd,
    output tgp_sts_t                      sts,
    input  wire logic [ACTION_W-1:0]      s_action,
    input  wire logic signed [DIST_W-1:0] s_move_distance,
    input  wire logic [RC_W-1:0]          s_read_row,
    input  wire logic [RC_W-1:0]          s_read_col,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [RC_W-1:0]               m_pos_x,
    output logic [RC_W-1:0]               m_pos_y,
    output logic [HEAD_W-1:0]             m_heading,
    output logic                          m_pen_is_down,
    output logic                          m_cell_marked,
    output logic                          m_turtle_shown
);

    localparam int CW = $clog2(GRID_SIZE);
    localparam int IW = ((CW > RC_W) ? CW : RC_W) + 1;
    localparam int SW = DIST_W + 2;
    localparam logic [CW-1:0]        MAX_C   = CW'(GRID_SIZE - 1);
    localparam logic signed [SW-1:0] SUM_MAX = SW'(GRID_SIZE - 1);
    localparam logic [IW-1:0]        GRID_W  = IW'(GRID_SIZE);

    // latched command
    logic [ACTION_W-1:0]      act_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic [RC_W-1:0]          rrow_reg;
    logic [RC_W-1:0]          rcol_reg;

    // turtle state
    logic [CW-1:0]     x_reg, y_reg, ox_reg, oy_reg;
    logic [HEAD_W-1:0] facing_reg;
    logic              pen_reg;
    logic              marker_reg;

    // row sweep
    logic [GRID_SIZE-1:0] vld_reg;
    logic [GRID_SIZE-1:0] mask_reg;
    logic [GRID_SIZE-1:0] mask_next;
    logic [CW-1:0]        row_cnt_reg, row_hi_reg, wr_row_reg;
    logic                 wr_pend_reg;

    logic                 m_valid_reg;

    // ram
    logic                 rd_en;
    logic [CW-1:0]        rd_addr;
    logic [GRID_SIZE-1:0] rd_data;
    logic [GRID_SIZE-1:0] wr_data;

    // move math
    logic                 horiz;
    logic [CW-1:0]        base;
    logic signed [SW-1:0] base_s, dist_s, sum;
    logic [CW-1:0]        clamped;
    logic                 moved_x, moved_y;
    logic [CW-1:0]        lo_x, hi_x, lo_y, hi_y;

    // read
    logic [IW-1:0] rrow_w, rcol_w, x_w, y_w;
    logic [CW-1:0] rrow_idx, rcol_idx;
    logic          is_read, in_range, marked, shown;

    always_comb begin
        horiz   = (facing_reg == HEAD_EAST) || (facing_reg == HEAD_WEST);
        base    = horiz ? x_reg : y_reg;
        base_s  = signed'(SW'(base));
        dist_s  = {{(SW-DIST_W){dist_reg[DIST_W-1]}}, dist_reg};
        if ((facing_reg == HEAD_NORTH) || (facing_reg == HEAD_WEST)) begin
            sum = base_s - dist_s;
        end else begin
            sum = base_s + dist_s;
        end
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > SUM_MAX) begin
            clamped = MAX_C;
        end else begin
            clamped = sum[CW-1:0];
        end
    end

    always_comb begin
        moved_x = (x_reg != ox_reg);
        moved_y = (y_reg != oy_reg);
        lo_x    = (x_reg < ox_reg) ? x_reg : ox_reg;
        hi_x    = (x_reg < ox_reg) ? ox_reg : x_reg;
        lo_y    = (y_reg < oy_reg) ? y_reg : oy_reg;
        hi_y    = (y_reg < oy_reg) ? oy_reg : y_reg;
        for (int i = 0; i < GRID_SIZE; i++) begin
            if (moved_x) begin
                mask_next[i] = (CW'(i) >= lo_x) && (CW'(i) <= hi_x);
            end else begin
                mask_next[i] = (CW'(i) == x_reg);
            end
        end
    end

    always_comb begin
        rrow_w   = IW'(rrow_reg);
        rcol_w   = IW'(rcol_reg);
        x_w      = IW'(x_reg);
        y_w      = IW'(y_reg);
        rrow_idx = rrow_w[CW-1:0];
        rcol_idx = rcol_w[CW-1:0];
        is_read  = (act_reg == ACT_READ);
        in_range = (rrow_w < GRID_W) && (rcol_w < GRID_W);
        marked   = is_read && in_range && vld_reg[rrow_idx] && rd_data[rcol_idx];
        shown    = is_read && in_range && (rrow_idx == y_reg) && (rcol_idx == x_reg)
                   && marker_reg;
    end

    assign rd_en   = cmd.sweep || (cmd.decode && is_read);
    assign rd_addr = cmd.sweep ? row_cnt_reg : rrow_idx;
    assign wr_data = (vld_reg[wr_row_reg] ? rd_data : '0) | mask_reg;

    tgp_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_grid (
        .clk     (aclk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_row_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_action;
            dist_reg <= s_move_distance;
            rrow_reg <= s_read_row;
            rcol_reg <= s_read_col;
        end
        if (cmd.plan) begin
            mask_reg    <= mask_next;
            row_cnt_reg <= moved_x ? y_reg : lo_y;
            row_hi_reg  <= moved_x ? y_reg : hi_y;
        end else if (cmd.sweep) begin
            row_cnt_reg <= row_cnt_reg + 1'b1;
        end
        if (cmd.sweep) begin
            wr_row_reg <= row_cnt_reg;
        end
        if (cmd.finish && sts.out_free) begin
            m_pos_x        <= x_w[RC_W-1:0];
            m_pos_y        <= y_w[RC_W-1:0];
            m_heading      <= facing_reg;
            m_pen_is_down  <= pen_reg;
            m_cell_marked  <= marked;
            m_turtle_shown <= shown;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            facing_reg  <= HEAD_EAST;
            pen_reg     <= 1'b0;
            marker_reg  <= 1'b1;
            vld_reg     <= '0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            wr_pend_reg <= cmd.sweep;
            if (wr_pend_reg) begin
                vld_reg[wr_row_reg] <= 1'b1;
            end
            if (cmd.decode) begin
                case (act_reg)
                    ACT_PEN_UP:   pen_reg    <= 1'b0;
                    ACT_PEN_DOWN: pen_reg    <= 1'b1;
                    ACT_RIGHT:    facing_reg <= facing_reg + 1'b1;
                    ACT_LEFT:     facing_reg <= facing_reg - 1'b1;
                    ACT_FORWARD: begin
                        ox_reg <= x_reg;
                        oy_reg <= y_reg;
                        if (horiz) begin
                            x_reg <= clamped;
                        end else begin
                            y_reg <= clamped;
                        end
                    end
                    ACT_MARK_ON:  marker_reg <= 1'b1;
                    ACT_MARK_OFF: marker_reg <= 1'b0;
                    ACT_RESET: begin
                        vld_reg    <= '0;
                        x_reg      <= '0;
                        y_reg      <= '0;
                        facing_reg <= HEAD_EAST;
                        pen_reg    <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.finish && sts.out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign sts.is_move    = (act_reg == ACT_FORWARD);
    assign sts.sweep_go   = pen_reg && (moved_x || moved_y);
    assign sts.sweep_last = (row_cnt_reg == row_hi_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

>>> rtl/turtle_grid_plotter.sv
// Every command returns one result beat; forward also updates the grid when the pen
// marks cells: a column of N cells (N up to GRID_SIZE) is swept with one grid row
// read-modify-written per cycle, while a row of cells needs only its own grid row.
// Throughput: one command at a time; next beat taken the cycle after the result loads.
// Reset (aresetn, synchronous): grid cleared at once through per-row valid bits,
// turtle at origin heading east, pen up, marker display on. No clearing pass.
`default_nettype none

`include "turtle_grid_plotter_assert.svh"

module turtle_grid_plotter
    import tgp_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [ACTION_W-1:0]      s_action,
    input  wire logic signed [DIST_W-1:0] s_move_distance,
    input  wire logic [RC_W-1:0]          s_read_row,
    input  wire logic [RC_W-1:0]          s_read_col,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [RC_W-1:0]               m_pos_x,
    output logic [RC_W-1:0]               m_pos_y,
    output logic [HEAD_W-1:0]             m_heading,
    output logic                          m_pen_is_down,
    output logic                          m_cell_marked,
    output logic                          m_turtle_shown
);

    tgp_cmd_t cmd;
    tgp_sts_t sts;

    tgp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tgp_dp #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_action        (s_action),
        .s_move_distance (s_move_distance),
        .s_read_row      (s_read_row),
        .s_read_col      (s_read_col),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pos_x         (m_pos_x),
        .m_pos_y         (m_pos_y),
        .m_heading       (m_heading),
        .m_pen_is_down   (m_pen_is_down),
        .m_cell_marked   (m_cell_marked),
        .m_turtle_shown  (m_turtle_shown)
    );

    `TGP_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "ready held after beat")
    `TGP_ASSERT_NEXT(a_result_loaded, cmd.finish && sts.out_free, m_valid, "result not loaded")
    `TGP_ASSERT_NEXT(a_plan_follows, cmd.decode && sts.is_move, cmd.plan, "move skipped plan")
    `TGP_ASSERT_SAME(a_sweep_busy, cmd.sweep, !s_ready && !cmd.finish, "sweep overlaps")

endmodule

`default_nettype wire

>>> test/turtle_grid_plotter_test.sv
`timescale 1ns / 100ps

module turtle_grid_plotter_test;
    import tgp_pkg::*;

    localparam int GRID_N = GRID_SIZE_DEF;

    typedef struct packed {
        logic [RC_W-1:0]   px;
        logic [RC_W-1:0]   py;
        logic [HEAD_W-1:0] hd;
        logic              pen;
        logic              marked;
        logic              shown;
    } turtle_status_t;

    class turtle_tracker;
        bit [GRID_N-1:0]   grid [GRID_N];
        bit [RC_W-1:0]     cur_x;
        bit [RC_W-1:0]     cur_y;
        bit [HEAD_W-1:0]   cur_head;
        bit                pen;
        bit                marker;
        turtle_status_t    expected_status[$];
        int                errors;

        function new();
            home();
            marker = 1'b1;
            errors = 0;
        endfunction

        function void home();
            foreach (grid[r]) grid[r] = '0;
            cur_x = '0;
            cur_y = '0;
            cur_head = HEAD_EAST;
            pen = 1'b0;
        endfunction

        function int clamp(int v);
            if (v < 0) return 0;
            if (v > GRID_N - 1) return GRID_N - 1;
            return v;
        endfunction

        function void move(logic signed [DIST_W-1:0] mv_dist);
            int d, ox, oy, nx, ny, lo, hi;
            d = int'(mv_dist);
            ox = cur_x;
            oy = cur_y;
            nx = ox;
            ny = oy;
            case (cur_head)
                HEAD_NORTH: ny = clamp(oy - d);
                HEAD_EAST:  nx = clamp(ox + d);
                HEAD_SOUTH: ny = clamp(oy + d);
                default:    nx = clamp(ox - d);
            endcase
            if (pen) begin
                if (nx != ox) begin
                    lo = (nx < ox) ? nx : ox;
                    hi = (nx < ox) ? ox : nx;
                    for (int i = lo; i <= hi; i++) grid[ny][i] = 1'b1;
                end else if (ny != oy) begin
                    lo = (ny < oy) ? ny : oy;
                    hi = (ny < oy) ? oy : ny;
                    for (int i = lo; i <= hi; i++) grid[i][nx] = 1'b1;
                end
            end
            cur_x = RC_W'(nx);
            cur_y = RC_W'(ny);
        endfunction

        function void note_command(logic [ACTION_W-1:0] act,
                                   logic signed [DIST_W-1:0] mv_dist,
                                   logic [RC_W-1:0] row, logic [RC_W-1:0] col);
            turtle_status_t st;
            st.marked = 1'b0;
            st.shown = 1'b0;
            case (act)
                ACT_PEN_UP:   pen = 1'b0;
                ACT_PEN_DOWN: pen = 1'b1;
                ACT_RIGHT:    cur_head = cur_head + 1'b1;
                ACT_LEFT:     cur_head = cur_head - 1'b1;
                ACT_FORWARD:  move(mv_dist);
                ACT_READ: begin
                    if (row < GRID_N && col < GRID_N) begin
                        st.marked = grid[row][col];
                        st.shown = (row == cur_y) && (col == cur_x) && marker;
                    end
                end
                ACT_MARK_ON:  marker = 1'b1;
                ACT_MARK_OFF: marker = 1'b0;
                ACT_RESET:    home();
                default: ;
            endcase
            st.px = cur_x;
            st.py = cur_y;
            st.hd = cur_head;
            st.pen = pen;
            expected_status.push_back(st);
        endfunction

        function void check_status(turtle_status_t got);
            turtle_status_t want;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: x=%0d y=%0d hd=%0d pen=%0b mk=%0b sh=%0b",
                             got.px, got.py, got.hd, got.pen, got.marked, got.shown);
                return;
            end
            want = expected_status.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.hd !== want.hd ||
                got.pen !== want.pen || got.marked !== want.marked ||
                got.shown !== want.shown) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp x=%0d y=%0d hd=%0d pen=%0b mk=%0b sh=%0b,",
                             want.px, want.py, want.hd, want.pen, want.marked, want.shown);
                    $display("          got x=%0d y=%0d hd=%0d pen=%0b mk=%0b sh=%0b",
                             got.px, got.py, got.hd, got.pen, got.marked, got.shown);
                end
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ACTION_W-1:0]      s_action = '0;
    logic signed [DIST_W-1:0] s_move_distance = '0;
    logic [RC_W-1:0]          s_read_row = '0;
    logic [RC_W-1:0]          s_read_col = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [RC_W-1:0]          m_pos_x;
    logic [RC_W-1:0]          m_pos_y;
    logic [HEAD_W-1:0]        m_heading;
    logic                     m_pen_is_down;
    logic                     m_cell_marked;
    logic                     m_turtle_shown;

    turtle_tracker tracker = new();
    int            cmds_taken = 0;
    int            burst_left = 0;

    turtle_grid_plotter u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_move_distance(s_move_distance),
        .s_read_row     (s_read_row),
        .s_read_col     (s_read_col),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_heading      (m_heading),
        .m_pen_is_down  (m_pen_is_down),
        .m_cell_marked  (m_cell_marked),
        .m_turtle_shown (m_turtle_shown)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_status({m_pos_x, m_pos_y, m_heading, m_pen_is_down,
                                  m_cell_marked, m_turtle_shown});
    end

    // receiver: stall modes of random length, plus one long hold-off
    initial begin
        int  mode, mode_left, hold_left;
        bit  hold_done, toggle;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        toggle = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && cmds_taken >= 500) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(1, 64);
            end
            mode_left--;
            toggle = ~toggle;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= toggle;
                endcase
            end
        end
    end

    task automatic pause_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic issue(logic [ACTION_W-1:0] act, logic signed [DIST_W-1:0] mv_dist,
                         logic [RC_W-1:0] row, logic [RC_W-1:0] col);
        s_valid <= 1'b1;
        s_action <= act;
        s_move_distance <= mv_dist;
        s_read_row <= row;
        s_read_col <= col;
        do @(posedge aclk); while (!s_ready);
        tracker.note_command(act, mv_dist, row, col);
        cmds_taken++;
        if (burst_left <= 0) begin
            pause_sender($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic random_command(output logic [ACTION_W-1:0] act,
                                  output logic signed [DIST_W-1:0] mv_dist,
                                  output logic [RC_W-1:0] row, output logic [RC_W-1:0] col);
        int pick, v;
        pick = $urandom_range(0, 99);
        mv_dist = DIST_W'($urandom);
        row = RC_W'($urandom);
        col = RC_W'($urandom);
        if (pick < 30) begin
            act = ACT_FORWARD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    v = $urandom_range(0, 80);
                    mv_dist = DIST_W'(v - 40);
                end
                6, 7: mv_dist = DIST_W'($urandom);
                8: mv_dist = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                default: begin
                    v = $urandom_range(31, 32);
                    mv_dist = DIST_W'($urandom_range(0, 1) ? v : -v);
                end
            endcase
        end else if (pick < 55) begin
            act = ACT_READ;
            if ($urandom_range(0, 2) == 0) begin
                row = tracker.cur_y;
                col = tracker.cur_x;
            end
        end else if (pick < 63) act = ACT_PEN_DOWN;
        else if (pick < 68) act = ACT_PEN_UP;
        else if (pick < 76) act = ACT_RIGHT;
        else if (pick < 84) act = ACT_LEFT;
        else if (pick < 88) act = ACT_MARK_ON;
        else if (pick < 91) act = ACT_MARK_OFF;
        else if (pick < 93) act = ACT_RESET;
        else if (pick < 96) act = ACT_NONE;
        else act = ACTION_W'($urandom_range(ACT_RESET + 1, 15));
    endtask

    initial begin
        logic [ACTION_W-1:0]      act;
        logic signed [DIST_W-1:0] mv_dist;
        logic [RC_W-1:0]          row;
        logic [RC_W-1:0]          col;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        issue(ACT_NONE, 16'sh7fff, 5'd31, 5'd31);
        issue(ACT_PEN_DOWN, '0, '0, '0);
        issue(ACT_FORWARD, 16'sh7fff, '0, '0);
        issue(ACT_FORWARD, 16'sd5, '0, '0);      // at the wall, nothing moves
        issue(ACT_RIGHT, '0, '0, '0);
        issue(ACT_FORWARD, 16'sh8000, '0, '0);
        issue(ACT_FORWARD, 16'sd31, '0, '0);
        issue(ACT_READ, '0, 5'd31, 5'd31);
        issue(ACT_READ, '0, 5'd0, 5'd0);
        issue(ACT_MARK_OFF, '0, '0, '0);
        issue(ACT_READ, '0, 5'd31, 5'd31);
        issue(ACT_LEFT, '0, '0, '0);
        issue(ACT_LEFT, '0, '0, '0);
        issue(ACT_LEFT, '0, '0, '0);             // wraps north to west
        issue(ACT_FORWARD, 16'sd1, '0, '0);
        issue(ACT_FORWARD, -16'sd1, '0, '0);
        issue(ACT_RIGHT, '0, '0, '0);            // wraps west to north
        issue(ACT_LEFT, '0, '0, '0);
        issue(ACT_PEN_UP, '0, '0, '0);
        issue(ACT_FORWARD, 16'sd100, '0, '0);
        issue(ACT_READ, '0, 5'd31, 5'd0);
        issue(ACT_RESET, 16'shffff, 5'd31, 5'd31);
        issue(ACT_READ, '0, 5'd0, 5'd0);
        issue(ACT_MARK_ON, '0, '0, '0);
        issue(ACT_READ, '0, 5'd0, 5'd0);
        for (int k = ACT_RESET + 1; k < 16; k++)
            issue(ACTION_W'(k), DIST_W'($urandom), RC_W'($urandom), RC_W'($urandom));

        for (int n = 0; n < 1200; n++) begin
            random_command(act, mv_dist, row, col);
            issue(act, mv_dist, row, col);
        end
        pause_sender(1);

        while (tracker.expected_status.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (tracker.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/tgp_pkg.sv
rtl/tgp_ram.sv
rtl/tgp_ctrl.sv
rtl/tgp_dp.sv
rtl/turtle_grid_plotter.sv
test/turtle_grid_plotter_test.sv
